// ===== src/waypoint_constant_speed_timing_assert.svh =====
`ifndef WAYPOINT_CONSTANT_SPEED_TIMING_ASSERT_SVH
`define WAYPOINT_CONSTANT_SPEED_TIMING_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define WCST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds.
`define WCST_ASSERT_NEVER(lbl, cond, msg) \
  `WCST_ASSERT(lbl, !(cond), msg)

`endif

// ===== src/wcst_pkg.sv =====
package wcst_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned TIME_WIDTH_DEF  = 48;
  localparam int unsigned SPEED_W = 31;
  localparam int unsigned THR_W   = 32;
  localparam int unsigned QUAT_W  = 16;
  localparam int unsigned VEL_W   = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned FRAC_W  = 16;

  localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(65536);
  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(66);

  localparam logic REG_SPEED = 1'b0;
  localparam logic REG_THR   = 1'b1;

  typedef struct packed {
    logic start;
    logic sqrt;
  } wcst_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wcst_sts_t;

  // shared unit numerator width: radicand or velocity dividend, whichever is wider
  function automatic int unsigned wcst_num_w(int unsigned c);
    return (2 * c + 2 > c + SPEED_W) ? 2 * c + 2 : c + SPEED_W;
  endfunction

  // divisor width: distance or speed
  function automatic int unsigned wcst_den_w(int unsigned c);
    return (c + 1 > SPEED_W) ? c + 1 : SPEED_W;
  endfunction

  function automatic int unsigned wcst_mulb_w(int unsigned c);
    return (c > SPEED_W) ? c : SPEED_W;
  endfunction

endpackage

// ===== src/wcst_mul.sv =====
module wcst_mul import wcst_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                             clk_i,
  input  logic [COORD_WIDTH-1:0]                           a_i,
  input  logic [wcst_mulb_w(COORD_WIDTH)-1:0]              b_i,
  output logic [COORD_WIDTH+wcst_mulb_w(COORD_WIDTH)-1:0]  prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= a_i * b_i;
  end

endmodule

// ===== src/wcst_divsqrt.sv =====
module wcst_divsqrt import wcst_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wcst_cmd_t                             cmd_i,
  input  logic [wcst_num_w(COORD_WIDTH)-1:0]    num_i,
  input  logic [wcst_den_w(COORD_WIDTH)-1:0]    den_i,
  output wcst_sts_t                             sts_o,
  output logic [wcst_num_w(COORD_WIDTH)-1:0]    res_o
);

  localparam int unsigned NW    = wcst_num_w(COORD_WIDTH);
  localparam int unsigned DW    = wcst_den_w(COORD_WIDTH);
  localparam int unsigned RW    = DW + 2;
  localparam int unsigned CNT_W = $clog2(NW + 1);
  localparam int unsigned SQ_STEPS  = COORD_WIDTH + 1;
  localparam int unsigned DIV_STEPS = COORD_WIDTH + SPEED_W;

  logic [NW-1:0]    num_q, res_q;
  logic [RW-1:0]    rem_q;
  logic [DW-1:0]    den_q;
  logic             sqrt_q, busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RW-1:0]    shifted, trial;
  logic             ge;

  // one restoring step: two radicand bits for root, one dividend bit for divide
  always_comb begin
    if (sqrt_q) begin
      shifted = {rem_q[RW-3:0], num_q[NW-1:NW-2]};
      trial   = {res_q[RW-3:0], 2'b01};
    end else begin
      shifted = {rem_q[RW-2:0], num_q[NW-1]};
      trial   = RW'(den_q);
    end
    ge = (shifted >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.sqrt ? CNT_W'(SQ_STEPS) : CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      num_q  <= num_i;
      den_q  <= den_i;
      sqrt_q <= cmd_i.sqrt;
      rem_q  <= '0;
      res_q  <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (shifted - trial) : shifted;
      res_q <= {res_q[NW-2:0], ge};
      num_q <= sqrt_q ? {num_q[NW-3:0], 2'b00} : {num_q[NW-2:0], 1'b0};
    end
  end

  assign sts_o = '{busy: busy_q, done: done_q};
  assign res_o = res_q;

endmodule

// ===== src/waypoint_constant_speed_timing.sv =====
// A path's first waypoint is held, and emitted as the final point if it ends the path.
// A compared waypoint squares its deltas on the multiplier, takes the root (COORD_WIDTH+1
// steps) on the shared shift-subtract unit and, if kept, runs three velocity divides
// (none at zero distance) and one time divide (COORD_WIDTH+31 steps each) on it too.
// A path end adds a final point; no new waypoint is taken until the sequencer is idle.
// Reset clears the held-valid flag and time and loads the speed and threshold defaults.
module waypoint_constant_speed_timing import wcst_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // cfg: index 0 speed, 1 dup_threshold
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
  input  logic [((3*COORD_WIDTH+4*QUAT_W+7)/8)*8-1:0] s_axis_tdata,
  input  logic             s_axis_tlast,  // path_end
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // stamp, out_x, out_y, out_z, out_qw, out_qx, out_qy, out_qz, vel_x, vel_y, vel_z
  output logic [((TIME_WIDTH+3*COORD_WIDTH+4*QUAT_W+3*VEL_W+7)/8)*8-1:0] m_axis_tdata,
  output logic             m_axis_tlast   // final_point
);

  `include "waypoint_constant_speed_timing_assert.svh"

  localparam int unsigned C     = COORD_WIDTH;
  localparam int unsigned NW    = wcst_num_w(C);
  localparam int unsigned DNW   = wcst_den_w(C);
  localparam int unsigned MBW   = wcst_mulb_w(C);
  localparam int unsigned PW    = C + MBW;
  localparam int unsigned N_W   = 2 * C + 2;
  localparam int unsigned D_W   = C + 1;
  localparam int unsigned DV_W  = C + SPEED_W;
  localparam int unsigned CMP_W = (D_W > THR_W) ? D_W : THR_W;
  localparam int unsigned SUM_W = ((TIME_WIDTH > DV_W) ? TIME_WIDTH : DV_W) + 1;
  localparam int unsigned OUT_W = ((TIME_WIDTH+3*C+4*QUAT_W+3*VEL_W+7)/8)*8;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_ROOT  = 4'd3;
  localparam logic [3:0] S_ROOTW = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_VM    = 4'd6;
  localparam logic [3:0] S_VMW   = 4'd7;
  localparam logic [3:0] S_VD    = 4'd8;
  localparam logic [3:0] S_TIME  = 4'd9;
  localparam logic [3:0] S_TW    = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state_q, state_d;

  logic [SPEED_W-1:0] speed_q;
  logic [THR_W-1:0]   thr_q;
  logic [SPEED_W-1:0] spd_eff;

  logic                         held_valid_q;
  logic [2:0][C-1:0]            held_pos_q, new_pos_q, in_pos;
  logic [3:0][QUAT_W-1:0]       held_quat_q, new_quat_q, in_quat;
  logic [TIME_WIDTH-1:0]        held_time_q;
  logic                         end_q;
  logic [2:0][C-1:0]            mag_q;
  logic [2:0]                   neg_q;
  logic [1:0]                   axis_q;
  logic [N_W-1:0]               n_q;
  logic [D_W-1:0]               d_q;
  logic [2:0][VEL_W-1:0]        vel_q;
  logic [DV_W-1:0]              dt_q;
  logic [SUM_W-1:0]             time_sum;
  logic [TIME_WIDTH-1:0]        time_next;

  logic                         m_valid_q, m_last_q;
  logic [TIME_WIDTH-1:0]        o_stamp_q;
  logic [2:0][C-1:0]            o_pos_q;
  logic [3:0][QUAT_W-1:0]       o_quat_q;
  logic [2:0][VEL_W-1:0]        o_vel_q;
  logic                         out_free, in_acc;

  logic [MBW-1:0]   mul_b;
  logic [PW-1:0]    prod;
  wcst_cmd_t        cmd;
  wcst_sts_t        sts;
  logic [NW-1:0]    unit_num, unit_res;
  logic [DNW-1:0]   unit_den;
  logic [VEL_W-1:0] quo;

  assign cfg_ready_o   = 1'b1;
  assign spd_eff       = (speed_q == '0) ? SPEED_W'(1) : speed_q;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  for (genvar i = 0; i < 3; i++) begin : g_pos
    assign in_pos[i] = s_axis_tdata[i*C +: C];
  end
  for (genvar i = 0; i < 4; i++) begin : g_quat
    assign in_quat[i] = s_axis_tdata[3*C + i*QUAT_W +: QUAT_W];
  end

  assign mul_b = (state_q == S_SQ) ? MBW'(mag_q[axis_q]) : MBW'(spd_eff);

  wcst_mul #(.COORD_WIDTH(C)) u_mul (
    .clk_i  (clk_i),
    .a_i    (mag_q[axis_q]),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    cmd      = '{start: 1'b0, sqrt: 1'b0};
    unit_num = '0;
    unit_den = '0;
    unique case (state_q)
      S_ROOT: begin
        cmd      = '{start: 1'b1, sqrt: 1'b1};
        unit_num = NW'(n_q) << (NW - N_W);
      end
      S_VMW: begin
        cmd      = '{start: 1'b1, sqrt: 1'b0};
        unit_num = NW'(prod[DV_W-1:0]) << (NW - DV_W);
        unit_den = DNW'(d_q);
      end
      S_TIME: begin
        cmd      = '{start: 1'b1, sqrt: 1'b0};
        unit_num = NW'({d_q, {FRAC_W{1'b0}}}) << (NW - DV_W);
        unit_den = DNW'(spd_eff);
      end
      default: begin
        cmd = '{start: 1'b0, sqrt: 1'b0};
      end
    endcase
  end

  wcst_divsqrt #(.COORD_WIDTH(C)) u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .num_i  (unit_num),
    .den_i  (unit_den),
    .sts_o  (sts),
    .res_o  (unit_res)
  );

  assign quo = unit_res[VEL_W-1:0];

  // saturate the time sum at the top of the stamp range
  assign time_sum  = SUM_W'(held_time_q) + SUM_W'(dt_q);
  assign time_next = (time_sum > SUM_W'({TIME_WIDTH{1'b1}})) ? {TIME_WIDTH{1'b1}}
                                                             : time_sum[TIME_WIDTH-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!held_valid_q) state_d = s_axis_tlast ? S_FIN : S_IDLE;
          else               state_d = S_SQ;
        end
      end
      S_SQ:    state_d = S_ACC;
      S_ACC:   state_d = (axis_q == 2'd2) ? S_ROOT : S_SQ;
      S_ROOT:  state_d = S_ROOTW;
      S_ROOTW: if (sts.done) state_d = S_CMP;
      S_CMP: begin
        if (CMP_W'(d_q) >= CMP_W'(thr_q)) state_d = (d_q == '0) ? S_TIME : S_VM;
        else                              state_d = end_q ? S_FIN : S_IDLE;
      end
      S_VM:    state_d = S_VMW;
      S_VMW:   state_d = S_VD;
      S_VD:    if (sts.done) state_d = (axis_q == 2'd2) ? S_TIME : S_VM;
      S_TIME:  state_d = S_TW;
      S_TW:    if (sts.done) state_d = S_EMIT;
      S_EMIT:  if (out_free) state_d = end_q ? S_FIN : S_IDLE;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      speed_q      <= SPEED_RESET;
      thr_q        <= THR_RESET;
      held_valid_q <= 1'b0;
      held_time_q  <= '0;
      m_valid_q    <= 1'b0;
      axis_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_SPEED) speed_q <= cfg_data_i[SPEED_W-1:0];
        else                          thr_q   <= cfg_data_i[THR_W-1:0];
      end
      // load a new item, else drop the one taken
      if ((state_q == S_EMIT || state_q == S_FIN) && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready)                                  m_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          axis_q <= '0;
          if (in_acc && !held_valid_q) held_valid_q <= 1'b1;
        end
        S_ACC: axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
        S_CMP: axis_q <= '0;
        S_VD:  if (sts.done) axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
        S_EMIT: begin
          if (out_free) begin
            held_time_q <= time_next;
          end
        end
        S_FIN: begin
          if (out_free) begin
            held_valid_q <= 1'b0;
            held_time_q  <= '0;
          end
        end
        default: begin
          axis_q <= axis_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          end_q      <= s_axis_tlast;
          new_pos_q  <= in_pos;
          new_quat_q <= in_quat;
          n_q        <= '0;
          if (!held_valid_q) begin
            held_pos_q  <= in_pos;
            held_quat_q <= in_quat;
          end
          for (int i = 0; i < 3; i++) begin
            logic [C:0] dl;
            dl = {in_pos[i][C-1], in_pos[i]} - {held_pos_q[i][C-1], held_pos_q[i]};
            neg_q[i] <= dl[C];
            mag_q[i] <= dl[C] ? C'(-dl) : dl[C-1:0];
          end
        end
      end
      S_ACC:   n_q <= n_q + N_W'(prod[2*C-1:0]);
      S_ROOTW: if (sts.done) d_q <= unit_res[D_W-1:0];
      S_CMP:   vel_q <= '0;
      S_VD:    if (sts.done) vel_q[axis_q] <= neg_q[axis_q] ? -quo : quo;
      S_TW:    if (sts.done) dt_q <= unit_res[DV_W-1:0];
      S_EMIT: begin
        if (out_free) begin
          o_stamp_q   <= held_time_q;
          o_pos_q     <= held_pos_q;
          o_quat_q    <= held_quat_q;
          o_vel_q     <= vel_q;
          m_last_q    <= 1'b0;
          held_pos_q  <= new_pos_q;
          held_quat_q <= new_quat_q;
        end
      end
      S_FIN: begin
        if (out_free) begin
          o_stamp_q <= held_time_q;
          o_pos_q   <= held_pos_q;
          o_quat_q  <= held_quat_q;
          o_vel_q   <= '0;
          m_last_q  <= 1'b1;
        end
      end
      default: begin
        n_q <= n_q;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = OUT_W'({o_vel_q[2], o_vel_q[1], o_vel_q[0],
                                 o_quat_q[3], o_quat_q[2], o_quat_q[1], o_quat_q[0],
                                 o_pos_q[2], o_pos_q[1], o_pos_q[0], o_stamp_q});

  `WCST_ASSERT(a_done_in_wait, sts.done |-> (state_q == S_ROOTW || state_q == S_VD ||
               state_q == S_TW), "shared unit finished outside a wait state")
  `WCST_ASSERT_NEVER(a_final_vel, m_axis_tvalid && m_axis_tlast && (o_vel_q != '0),
                     "final point carries nonzero velocity")
  `WCST_ASSERT(a_fin_clears, (state_q == S_FIN && out_free) |=>
               (!held_valid_q && held_time_q == '0), "path end did not clear held state")
  `WCST_ASSERT_NEVER(a_busy_ready, sts.busy && s_axis_tready,
                     "input ready while shared unit busy")

endmodule

// ===== verif/tb.sv =====
module tb;
  import wcst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W  = ((3*32+4*16+7)/8)*8;
  localparam int OUT_W = ((48+3*32+4*16+3*32+7)/8)*8;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [47:0] stamp;
    logic [31:0] px, py, pz;
    logic [15:0] qw, qx, qy, qz;
    logic [31:0] vx, vy, vz;
    logic        fin;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = REG_SPEED;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  waypoint_constant_speed_timing dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [30:0] cur_speed;
  logic [31:0] cur_thr;
  bit          hold_ok;
  logic signed [31:0] hold_pos [3];
  logic [15:0] hold_quat [4];
  logic [47:0] hold_time;
  point_t      pending_pts[$];
  int          errors = 0;
  bit          stall_en = 1'b1;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 300);
  endfunction

  function automatic point_t make_point(logic [31:0] vx, vy, vz, logic fin);
    point_t pt;
    pt.stamp = hold_time;
    pt.px = hold_pos[0]; pt.py = hold_pos[1]; pt.pz = hold_pos[2];
    pt.qw = hold_quat[0]; pt.qx = hold_quat[1]; pt.qy = hold_quat[2]; pt.qz = hold_quat[3];
    pt.vx = vx; pt.vy = vy; pt.vz = vz; pt.fin = fin;
    return pt;
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] root;
    logic [129:0] rem, trial;
    root = 0; rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | n[2*i +: 2];
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[62:0], 1'b1};
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // quotient saturated to 64 bits
  function automatic logic [63:0] sat_div(logic [127:0] n, logic [63:0] den);
    logic [127:0] q;
    q = n / den;
    if (q[127:64] != 0) return '1;
    return q[63:0];
  endfunction

  task automatic predict_waypoint(logic [IN_W-1:0] data, logic last);
    logic signed [31:0] p [3];
    logic [15:0] q [4];
    logic signed [33:0] dl [3];
    logic [32:0] mg [3];
    logic [31:0] vel [3];
    logic [127:0] nsq;
    logic [63:0] d, dt, m, spd;
    for (int i = 0; i < 3; i++) p[i] = data[32*i +: 32];
    for (int i = 0; i < 4; i++) q[i] = data[96 + 16*i +: 16];
    spd = (cur_speed == 0) ? 64'd1 : 64'(cur_speed);
    if (!hold_ok) begin
      hold_pos = p; hold_quat = q; hold_ok = 1'b1;
      if (last) begin
        pending_pts.push_back(make_point(0, 0, 0, 1'b1));
        hold_ok = 1'b0; hold_time = 0;
      end
      return;
    end
    nsq = 0;
    for (int i = 0; i < 3; i++) begin
      dl[i] = 34'(p[i]) - 34'(hold_pos[i]);
      mg[i] = dl[i][33] ? 33'(-dl[i]) : 33'(dl[i]);
      nsq += 128'(mg[i]) * 128'(mg[i]);
      vel[i] = 0;
    end
    d = isqrt(nsq);
    if (d >= 64'(cur_thr)) begin
      if (d != 0) begin
        for (int i = 0; i < 3; i++) begin
          m = sat_div(128'(mg[i]) * 128'(spd), d);
          vel[i] = dl[i][33] ? 32'(-m) : 32'(m);
        end
      end
      pending_pts.push_back(make_point(vel[0], vel[1], vel[2], 1'b0));
      dt = sat_div(128'(d) << 16, spd);
      if (dt > 64'(TIME_MAX) || 64'(hold_time) > 64'(TIME_MAX) - dt) hold_time = TIME_MAX;
      else hold_time = hold_time + dt[47:0];
      hold_pos = p; hold_quat = q;
    end
    if (last) begin
      pending_pts.push_back(make_point(0, 0, 0, 1'b1));
      hold_ok = 1'b0; hold_time = 0;
    end
  endtask

  // valid stays high after the handshake; the next call or drain replaces or drops it
  task automatic send_waypoint(logic signed [31:0] x, y, z, logic [63:0] quat, logic last);
    int g;
    logic [IN_W-1:0] data;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    data = '0;
    data[31:0] = x; data[63:32] = y; data[95:64] = z; data[159:96] = quat;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_waypoint(data, last);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_SPEED) cur_speed = val[30:0];
    else cur_thr = val;
    @(posedge clk_i);
  endtask

  // wait for drain, then the longest compare latency
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // ready driver
  always @(posedge clk_i) begin
    static int hold_cnt = 0;
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (stall_en && $urandom_range(0, 3) == 0) begin
      hold_cnt = gap_len();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    point_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.stamp = m_axis_tdata[47:0];
      got.px = m_axis_tdata[79:48]; got.py = m_axis_tdata[111:80]; got.pz = m_axis_tdata[143:112];
      got.qw = m_axis_tdata[159:144]; got.qx = m_axis_tdata[175:160];
      got.qy = m_axis_tdata[191:176]; got.qz = m_axis_tdata[207:192];
      got.vx = m_axis_tdata[239:208]; got.vy = m_axis_tdata[271:240];
      got.vz = m_axis_tdata[303:272]; got.fin = m_axis_tlast;
      if (pending_pts.size() == 0) begin
        $error("unexpected point %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_pts.pop_front();
        if (got.stamp != want.stamp) begin $error("stamp exp %h got %h", want.stamp, got.stamp); errors++; end
        if (got.px != want.px) begin $error("out_x exp %h got %h", want.px, got.px); errors++; end
        if (got.py != want.py) begin $error("out_y exp %h got %h", want.py, got.py); errors++; end
        if (got.pz != want.pz) begin $error("out_z exp %h got %h", want.pz, got.pz); errors++; end
        if (got.qw != want.qw) begin $error("out_qw exp %h got %h", want.qw, got.qw); errors++; end
        if (got.qx != want.qx) begin $error("out_qx exp %h got %h", want.qx, got.qx); errors++; end
        if (got.qy != want.qy) begin $error("out_qy exp %h got %h", want.qy, got.qy); errors++; end
        if (got.qz != want.qz) begin $error("out_qz exp %h got %h", want.qz, got.qz); errors++; end
        if (got.vx != want.vx) begin $error("vel_x exp %h got %h", want.vx, got.vx); errors++; end
        if (got.vy != want.vy) begin $error("vel_y exp %h got %h", want.vy, got.vy); errors++; end
        if (got.vz != want.vz) begin $error("vel_z exp %h got %h", want.vz, got.vz); errors++; end
        if (got.fin != want.fin) begin $error("final_point exp %b got %b", want.fin, got.fin); errors++; end
      end
    end
  end

  function automatic logic [63:0] rand_quat();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    // lone point
    send_waypoint(32'sd0, 32'sd0, 32'sd0, 64'h7FFF_0000_0000_0000, 1'b1);
    // extremes of position and quaternion
    send_waypoint(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 64'h8000_8000_8000_8000, 1'b0);
    send_waypoint(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0);
    // duplicate dropped
    send_waypoint(32'h7FFF_FFFF, 32'h7FFF_FFF0, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_waypoint(32'sd0, 32'sd65536, -32'sd65536, 64'h0, 1'b1);
    // dropped final waypoint
    send_waypoint(32'sd100, 32'sd100, 32'sd100, 64'h1234_5678_9ABC_DEF0, 1'b0);
    send_waypoint(32'sd110, 32'sd100, 32'sd100, 64'h0, 1'b1);
    drain();
    // zero distance kept, zero speed, tiny speed saturates the time
    write_reg(REG_THR, 32'd0);
    write_reg(REG_SPEED, 32'd0);
    send_waypoint(32'sd5, 32'sd5, 32'sd5, 64'h1, 1'b0);
    send_waypoint(32'sd5, 32'sd5, 32'sd5, 64'h2, 1'b0);
    send_waypoint(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 64'h3, 1'b0);
    send_waypoint(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 64'h4, 1'b0);
    send_waypoint(32'sd0, 32'sd0, 32'sd0, 64'h5, 1'b1);
    drain();
    write_reg(REG_SPEED, 32'h7FFF_FFFF);
    write_reg(REG_THR, 32'hFFFF_FFFF);
    send_waypoint(32'h8000_0000, 32'sd0, 32'sd0, 64'h6, 1'b0);
    send_waypoint(32'h7FFF_FFFF, 32'sd0, 32'sd0, 64'h7, 1'b1);
    drain();
  endtask

  task automatic test_random_paths();
    int plen, sc;
    logic signed [31:0] x, y, z;
    logic [31:0] st;
    for (int n = 0; n < 800;) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        sc = $urandom_range(0, 4);
        case (sc)
          0: write_reg(REG_SPEED, 32'd1 << $urandom_range(0, 30));
          1: write_reg(REG_SPEED, $urandom);
          default: write_reg(REG_SPEED, $urandom_range(4096, 1 << 20));
        endcase
        sc = $urandom_range(0, 3);
        case (sc)
          0: write_reg(REG_THR, 32'd0);
          1: write_reg(REG_THR, $urandom);
          default: write_reg(REG_THR, $urandom_range(0, 1 << 18));
        endcase
      end
      plen = $urandom_range(1, 12);
      x = $urandom; y = $urandom; z = $urandom;
      for (int k = 0; k < plen; k++) begin
        sc = $urandom_range(0, 9);
        if (sc == 0) begin
          x = $urandom; y = $urandom; z = $urandom;
        end else if (sc == 1) begin
          st = 0; // repeat point
        end else begin
          st = 32'd1 << $urandom_range(4, 24);
          x = x + $signed($urandom_range(0, 2*st) - st);
          y = y + $signed($urandom_range(0, 2*st) - st);
          z = z + $signed($urandom_range(0, 2*st) - st);
        end
        send_waypoint(x, y, z, rand_quat(), (k == plen - 1));
        n++;
      end
    end
    drain();
  endtask

  initial begin
    cur_speed = SPEED_RESET;
    cur_thr = THR_RESET;
    hold_ok = 1'b0;
    hold_time = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_paths();
    stall_en = 1'b0;
    drain();
    if (errors == 0 && pending_pts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #600ms;
    $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/wcst_pkg.sv
src/wcst_mul.sv
src/wcst_divsqrt.sv
src/waypoint_constant_speed_timing.sv
verif/tb.sv
